@@ design/sorted_rectangle_run_merger_top_defines.svh @@
// Assertion macros for the sorted rectangle run merger.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SORTED_RECTANGLE_RUN_MERGER_TOP_DEFINES_SVH
`define SORTED_RECTANGLE_RUN_MERGER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRRM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/srrm_pkg.sv @@
// Shared constants and types for the sorted rectangle run merger.
// No dependencies; imported by the interfaces and all modules.
package srrm_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TYPE_BITS      = 8;
  localparam int TILE_BITS      = 11;
  localparam int MODE_BITS      = 2;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = TILE_BITS;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [TILE_BITS-1:0] TILE_SIZE_RST = TILE_BITS'(16);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILE_SIZE  = 1'b1;

  // Break test selection
  typedef enum logic [MODE_BITS-1:0] {
    MODE_DIST      = 2'd0,
    MODE_ADJ_SIZE  = 2'd1,
    MODE_TYPE_DIST = 2'd2
  } mode_e;

  // Core to top status
  typedef struct packed {
    logic [1:0] n_push;
    logic       run_open;
  } srrm_push_t;

endpackage

@@ design/srrm_if.sv @@
// Valid/ready channel interfaces for rectangles in and merged rectangles out.
// Depends on srrm_pkg for the default coordinate width.
interface srrm_rect_if import srrm_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] in_left;
  logic signed [CoordBits-1:0] in_top;
  logic        [CoordBits-1:0] in_width;
  logic        [CoordBits-1:0] in_height;
  logic        [TYPE_BITS-1:0] in_block_type;
  logic                        in_last;

  modport source (output valid, in_left, in_top, in_width, in_height, in_block_type,
                  in_last, input ready);
  modport sink (input valid, in_left, in_top, in_width, in_height, in_block_type,
                in_last, output ready);
endinterface

interface srrm_merged_if import srrm_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] out_left;
  logic signed [CoordBits-1:0] out_top;
  logic        [CoordBits-1:0] out_width;
  logic        [CoordBits-1:0] out_height;
  logic        [TYPE_BITS-1:0] out_block_type;
  logic                        out_final;

  modport source (output valid, out_left, out_top, out_width, out_height, out_block_type,
                  out_final, input ready);
  modport sink (input valid, out_left, out_top, out_width, out_height, out_block_type,
                out_final, output ready);
endinterface

@@ design/sorted_rectangle_run_merger_top.sv @@
// Sorted rectangle run merger: input register, merge core, result queue.
// An input transfer is registered, then its results are written into the result queue.
// Throughput: one rectangle per cycle while the 4-entry result queue has room for two;
// a last rectangle that closes a run yields two results, drained one per ready cycle.
// Reset clears the run state and queue and sets merge_mode 0, tile_size 16.
// Depends on srrm_pkg, srrm_if, srrm_core, srrm_out_fifo and the defines header.
`include "sorted_rectangle_run_merger_top_defines.svh"

module sorted_rectangle_run_merger_top import srrm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  srrm_rect_if.sink                rect_i,
  srrm_merged_if.source            merged_o
);
  localparam int CB = COORD_BITS;
  localparam int RW = 4 * CB + TYPE_BITS + 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  logic [MODE_BITS-1:0] merge_mode_q;
  logic [TILE_BITS-1:0] tile_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_mode_q <= MODE_DIST;
      tile_size_q  <= TILE_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MERGE_MODE: merge_mode_q <= cfg_data_i[MODE_BITS-1:0];
        REG_TILE_SIZE:  tile_size_q  <= cfg_data_i[TILE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // Input register stage
  logic                 in_valid_q;
  logic signed [CB-1:0] in_left_q, in_top_q;
  logic [CB-1:0]        in_width_q, in_height_q;
  logic [TYPE_BITS-1:0] in_type_q;
  logic                 in_last_q;
  logic                 adv, in_xfer, pop;
  logic [CW-1:0]        fifo_count;
  logic [RW-1:0]        res0, res1, fifo_dout;
  srrm_push_t           core_st;

  // Advance only with room for two results in the queue
  assign adv          = in_valid_q && (fifo_count <= CW'(FIFO_DEPTH - 2));
  assign rect_i.ready = !in_valid_q || adv;
  assign in_xfer      = rect_i.valid && rect_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rect_i.ready) begin
      in_valid_q <= rect_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_left_q   <= rect_i.in_left;
      in_top_q    <= rect_i.in_top;
      in_width_q  <= rect_i.in_width;
      in_height_q <= rect_i.in_height;
      in_type_q   <= rect_i.in_block_type;
      in_last_q   <= rect_i.in_last;
    end
  end

  srrm_core #(
    .COORD_BITS (CB)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .merge_mode_i (merge_mode_q),
    .tile_size_i  (tile_size_q),
    .left_i       (in_left_q),
    .top_i        (in_top_q),
    .width_i      (in_width_q),
    .height_i     (in_height_q),
    .type_i       (in_type_q),
    .last_i       (in_last_q),
    .res0_o       (res0),
    .res1_o       (res1),
    .status_o     (core_st)
  );

  srrm_out_fifo #(
    .Width (RW),
    .Depth (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (core_st.n_push),
    .din0_i   (res0),
    .din1_i   (res1),
    .pop_i    (pop),
    .dout_o   (fifo_dout),
    .count_o  (fifo_count)
  );

  // Output channel from the queue head
  assign merged_o.valid          = (fifo_count != '0);
  assign pop                     = merged_o.valid && merged_o.ready;
  assign merged_o.out_left       = fifo_dout[RW-1 -: CB];
  assign merged_o.out_top        = fifo_dout[RW-1-CB -: CB];
  assign merged_o.out_width      = fifo_dout[RW-1-2*CB -: CB];
  assign merged_o.out_height     = fifo_dout[RW-1-3*CB -: CB];
  assign merged_o.out_block_type = fifo_dout[TYPE_BITS:1];
  assign merged_o.out_final      = fifo_dout[0];

  // Checks
  `SRRM_ASSERT_IMPL(a_queue_room, adv, fifo_count <= CW'(FIFO_DEPTH - 2), "queue overrun")
  `SRRM_ASSERT_IMPL(a_pair_ends_final, core_st.n_push == 2'd2, res1[0] && !res0[0] && in_last_q, "pair order wrong")
  `SRRM_ASSERT_NEXT(a_flush_closes, adv && in_last_q, !core_st.run_open, "run open after flush")

endmodule

@@ design/srrm_out_fifo.sv @@
// Result queue: takes up to two results per cycle, gives one per cycle while popped.
// Depends on srrm_pkg for the default depth (power of two, at least 4).
module srrm_out_fifo import srrm_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     push_n_i,
  input  logic [Width-1:0]               din0_i,
  input  logic [Width-1:0]               din1_i,
  input  logic                           pop_i,
  output logic [Width-1:0]               dout_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);
  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CW-1:0]    count_q, count_d;

  assign wr_nxt   = wr_ptr_q + PW'(1);
  assign wr_ptr_d = wr_ptr_q + PW'(push_n_i);
  assign rd_ptr_d = rd_ptr_q + PW'(pop_i);
  assign count_d  = count_q + CW'(push_n_i) - CW'(pop_i);

  // Storage, first result then second
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= din0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= din1_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign dout_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

@@ design/srrm_core.sv @@
// Run state, break test and bounding-box growth for one rectangle per cycle while adv_i is high.
// Depends on srrm_pkg; results are packed {left, top, width, height, type, final}.
module srrm_core import srrm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic [MODE_BITS-1:0]                 merge_mode_i,
  input  logic [TILE_BITS-1:0]                 tile_size_i,
  input  logic signed [COORD_BITS-1:0]         left_i,
  input  logic signed [COORD_BITS-1:0]         top_i,
  input  logic [COORD_BITS-1:0]                width_i,
  input  logic [COORD_BITS-1:0]                height_i,
  input  logic [TYPE_BITS-1:0]                 type_i,
  input  logic                                 last_i,
  output logic [4*COORD_BITS+TYPE_BITS:0]      res0_o,
  output logic [4*COORD_BITS+TYPE_BITS:0]      res1_o,
  output srrm_push_t                           status_o
);
  localparam int CB = COORD_BITS;
  localparam int EW = CB + 2;                         // edge sums
  localparam int GW = CB + 3;                         // span of merged box
  localparam int DW = (CB > TILE_BITS) ? CB : TILE_BITS;
  localparam int SQ = 2 * TILE_BITS;
  localparam logic [CB-1:0] SIZE_MAX = {CB{1'b1}};

  // Run and previous rectangle state
  logic signed [CB-1:0] run_left_q, run_left_d, run_top_q, run_top_d;
  logic [CB-1:0]        run_width_q, run_width_d, run_height_q, run_height_d;
  logic [TYPE_BITS-1:0] run_type_q, run_type_d;
  logic signed [CB-1:0] prev_left_q, prev_top_q;
  logic [CB-1:0]        prev_width_q, prev_height_q;
  logic [TYPE_BITS-1:0] prev_type_q;
  logic                 run_open_q;

  // Distance test
  logic signed [CB:0]   dl, dt;
  logic [CB-1:0]        adx, ady;
  logic [DW-1:0]        dxe, dye;
  logic [SQ-1:0]        sqx, sqy, sqt;
  logic [SQ:0]          sq_sum;
  logic                 too_far;

  // Adjacency test
  logic signed [EW-1:0] l_e, t_e, pl_e, pt_e, r_new, b_new, r_prev, b_prev;
  logic                 touch, not_adj_same;

  // Growth
  logic signed [EW-1:0] r_run, b_run, nr, nb;
  logic signed [CB-1:0] nl, nt;
  logic signed [GW-1:0] span_w, span_h;
  logic                 brk, emit_old;

  assign dl  = (CB+1)'(left_i) - (CB+1)'(prev_left_q);
  assign dt  = (CB+1)'(top_i) - (CB+1)'(prev_top_q);
  assign adx = dl[CB] ? CB'(-dl) : CB'(dl);
  assign ady = dt[CB] ? CB'(-dt) : CB'(dt);
  assign dxe = DW'(adx);
  assign dye = DW'(ady);

  // Squares only matter once both offsets are within the tile size
  assign sqx    = dxe[TILE_BITS-1:0] * dxe[TILE_BITS-1:0];
  assign sqy    = dye[TILE_BITS-1:0] * dye[TILE_BITS-1:0];
  assign sqt    = tile_size_i * tile_size_i;
  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};
  assign too_far = (dxe > DW'(tile_size_i)) || (dye > DW'(tile_size_i)) ||
                   (sq_sum > {1'b0, sqt});

  // Closed-edge touch and equal size against the previous rectangle
  assign l_e    = EW'(left_i);
  assign t_e    = EW'(top_i);
  assign pl_e   = EW'(prev_left_q);
  assign pt_e   = EW'(prev_top_q);
  assign r_new  = l_e + $signed({2'b00, width_i});
  assign b_new  = t_e + $signed({2'b00, height_i});
  assign r_prev = pl_e + $signed({2'b00, prev_width_q});
  assign b_prev = pt_e + $signed({2'b00, prev_height_q});
  assign touch  = (pl_e <= r_new) && (l_e <= r_prev) && (pt_e <= b_new) && (t_e <= b_prev);
  assign not_adj_same = !(touch && (prev_width_q == width_i) && (prev_height_q == height_i));

  // Break test selection; the unused code follows the type-or-distance test
  always_comb begin
    if (!run_open_q) begin
      brk = 1'b1;
    end else begin
      case (merge_mode_i)
        MODE_DIST:      brk = too_far;
        MODE_ADJ_SIZE:  brk = not_adj_same;
        MODE_TYPE_DIST: brk = (prev_type_q != type_i) || too_far;
        default:        brk = (prev_type_q != type_i) || too_far;
      endcase
    end
  end

  // Bounding box of run and new rectangle
  assign r_run  = EW'(run_left_q) + $signed({2'b00, run_width_q});
  assign b_run  = EW'(run_top_q) + $signed({2'b00, run_height_q});
  assign nl     = (left_i < run_left_q) ? left_i : run_left_q;
  assign nt     = (top_i < run_top_q) ? top_i : run_top_q;
  assign nr     = (r_new > r_run) ? r_new : r_run;
  assign nb     = (b_new > b_run) ? b_new : b_run;
  assign span_w = GW'(nr) - GW'(nl);
  assign span_h = GW'(nb) - GW'(nt);

  always_comb begin
    if (brk) begin
      run_left_d   = left_i;
      run_top_d    = top_i;
      run_width_d  = width_i;
      run_height_d = height_i;
      run_type_d   = type_i;
    end else begin
      run_left_d   = nl;
      run_top_d    = nt;
      run_type_d   = run_type_q;
      // saturate spans to the size range
      if (span_w < 0) begin
        run_width_d = '0;
      end else if (span_w > $signed({3'b000, SIZE_MAX})) begin
        run_width_d = SIZE_MAX;
      end else begin
        run_width_d = span_w[CB-1:0];
      end
      if (span_h < 0) begin
        run_height_d = '0;
      end else if (span_h > $signed({3'b000, SIZE_MAX})) begin
        run_height_d = SIZE_MAX;
      end else begin
        run_height_d = span_h[CB-1:0];
      end
    end
  end

  // Results: closed run first, then the flushed run on last
  assign emit_old = run_open_q && brk;
  assign res1_o   = {run_left_d, run_top_d, run_width_d, run_height_d, run_type_d, 1'b1};
  assign res0_o   = emit_old ?
                    {run_left_q, run_top_q, run_width_q, run_height_q, run_type_q, 1'b0} :
                    res1_o;

  always_comb begin
    status_o.run_open = run_open_q;
    status_o.n_push   = adv_i ? (2'(emit_old) + 2'(last_i)) : 2'd0;
  end

  // State update on each transfer into the core
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_left_q    <= '0;
      run_top_q     <= '0;
      run_width_q   <= '0;
      run_height_q  <= '0;
      run_type_q    <= '0;
      prev_left_q   <= '0;
      prev_top_q    <= '0;
      prev_width_q  <= '0;
      prev_height_q <= '0;
      prev_type_q   <= '0;
      run_open_q    <= 1'b0;
    end else if (adv_i) begin
      run_left_q    <= run_left_d;
      run_top_q     <= run_top_d;
      run_width_q   <= run_width_d;
      run_height_q  <= run_height_d;
      run_type_q    <= run_type_d;
      prev_left_q   <= left_i;
      prev_top_q    <= top_i;
      prev_width_q  <= width_i;
      prev_height_q <= height_i;
      prev_type_q   <= type_i;
      run_open_q    <= !last_i;
    end
  end

endmodule

@@ tb/sorted_rectangle_run_merger_top_test.sv @@
// Testbench for the sorted rectangle run merger top level.
// Depends on srrm_pkg, srrm_if and the design; self-checking against an internal run predictor.
`timescale 1ns / 100ps

module sorted_rectangle_run_merger_top_test;
  import srrm_pkg::*;

  localparam int          CB           = COORD_BITS_DEF;
  localparam longint      SIZE_MAX     = (longint'(1) << CB) - 1;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          PHASE_RECTS  = 230;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  // Selector value the block treats like the type-or-distance test
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [CB-1:0] left;
    logic signed [CB-1:0] top;
    logic [CB-1:0]        width;
    logic [CB-1:0]        height;
    logic [TYPE_BITS-1:0] btype;
    logic                 last;
  } rect_t;

  typedef struct packed {
    logic [CB-1:0]        left;
    logic [CB-1:0]        top;
    logic [CB-1:0]        width;
    logic [CB-1:0]        height;
    logic [TYPE_BITS-1:0] btype;
    logic                 is_final;
  } run_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  srrm_rect_if   rect_ch ();
  srrm_merged_if merged_ch ();

  sorted_rectangle_run_merger_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rect_i     (rect_ch),
    .merged_o   (merged_ch)
  );

  // Stimulus and scoreboard storage
  rect_t       pending_rects[$];
  run_t        expected_runs[$];
  int          n_queued;
  int          n_accepted;
  int          n_checked;
  int          n_errors;
  int          n_settings;
  int unsigned cycle_count;

  // Mirror of the configuration registers
  logic [MODE_BITS-1:0] mode_q;
  longint               tile_q;

  // Predicted run state and previous raw rectangle
  bit                   run_open;
  longint               run_left, run_top, run_width, run_height;
  logic [TYPE_BITS-1:0] run_type;
  longint               last_left, last_top, last_width, last_height;
  logic [TYPE_BITS-1:0] last_type;

  // Sender burst state, receiver stall state
  int    burst_left;
  int    gap_left;
  rect_t drv_rect;
  int    stall_tick;
  int    stall_style;

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    if (n_errors < 50) $display("  mismatch: %s", msg);
    n_errors++;
  endtask

  // Origin distance test against the previous rectangle
  function automatic bit too_far(input longint l, input longint t);
    longint dx, dy;
    dx = (l >= last_left) ? l - last_left : last_left - l;
    dy = (t >= last_top) ? t - last_top : last_top - t;
    if (dx > tile_q || dy > tile_q) return 1'b1;
    return (dx * dx + dy * dy) > (tile_q * tile_q);
  endfunction

  function automatic void push_run(input bit fin);
    run_t r;
    r.left     = run_left[CB-1:0];
    r.top      = run_top[CB-1:0];
    r.width    = run_width[CB-1:0];
    r.height   = run_height[CB-1:0];
    r.btype    = run_type;
    r.is_final = fin;
    expected_runs.insert(expected_runs.size(), r);
  endfunction

  // Fold one accepted rectangle into the run, queue the runs it closes
  function automatic void fold_rectangle(input rect_t r);
    longint l, t, w, h, nl, nt, nr, nb;
    bit     brk, touch;
    l = $signed(r.left);
    t = $signed(r.top);
    w = longint'(r.width);
    h = longint'(r.height);
    if (!run_open) begin
      brk = 1'b1;
    end else begin
      case (mode_q)
        MODE_DIST: brk = too_far(l, t);
        MODE_ADJ_SIZE: begin
          touch = last_left <= l + w && l <= last_left + last_width &&
                  last_top <= t + h && t <= last_top + last_height;
          brk = !(touch && last_width == w && last_height == h);
        end
        default: brk = (last_type != r.btype) || too_far(l, t);
      endcase
    end
    if (brk) begin
      if (run_open) push_run(1'b0);
      run_left   = l;
      run_top    = t;
      run_width  = w;
      run_height = h;
      run_type   = r.btype;
      run_open   = 1'b1;
    end else begin
      nl = (l < run_left) ? l : run_left;
      nt = (t < run_top) ? t : run_top;
      nr = (l + w > run_left + run_width) ? l + w : run_left + run_width;
      nb = (t + h > run_top + run_height) ? t + h : run_top + run_height;
      run_left   = nl;
      run_top    = nt;
      run_width  = (nr - nl > SIZE_MAX) ? SIZE_MAX : nr - nl;
      run_height = (nb - nt > SIZE_MAX) ? SIZE_MAX : nb - nt;
    end
    last_left   = l;
    last_top    = t;
    last_width  = w;
    last_height = h;
    last_type   = r.btype;
    if (r.last) begin
      push_run(1'b1);
      run_open = 1'b0;
    end
  endfunction

  function automatic void queue_rect(input logic [CB-1:0] l, input logic [CB-1:0] t,
                                     input logic [CB-1:0] w, input logic [CB-1:0] h,
                                     input logic [TYPE_BITS-1:0] ty, input logic lst);
    rect_t r;
    r.left   = l;
    r.top    = t;
    r.width  = w;
    r.height = h;
    r.btype  = ty;
    r.last   = lst;
    pending_rects.insert(pending_rects.size(), r);
    n_queued++;
  endfunction

  // Mostly small sizes, sometimes the full range or its ends
  function automatic longint rand_size();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 2) return longint'($urandom_range(0, 65535));
    if (sel == 2) return ($urandom_range(0, 1) != 0) ? SIZE_MAX : 0;
    return longint'($urandom_range(1, 64));
  endfunction

  // One sorted list: steps sized to the current break test, with some
  // size and type changes, oversized steps and raw noise mixed in
  task automatic queue_row();
    int                   len, sel;
    longint               l, t, w, h, sx, sy, dx, dy;
    logic [TYPE_BITS-1:0] ty;
    bit                   lst;
    len = $urandom_range(1, 30);
    l   = $signed(CB'($urandom()));
    t   = $signed(CB'($urandom()));
    w   = rand_size();
    h   = rand_size();
    ty  = TYPE_BITS'($urandom());
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 19);
      lst = (i == len - 1) && ($urandom_range(0, 4) != 0);
      if (sel == 0) begin
        queue_rect(CB'($urandom()), CB'($urandom()), CB'($urandom()), CB'($urandom()),
                   TYPE_BITS'($urandom()), 1'($urandom()));
      end else begin
        if (sel == 1) begin
          w = rand_size();
          h = rand_size();
        end
        if (sel == 2) ty = TYPE_BITS'($urandom());
        sx = (mode_q == MODE_ADJ_SIZE) ? w : tile_q;
        sy = (mode_q == MODE_ADJ_SIZE) ? h : tile_q;
        if (i > 0) begin
          dx = (sel == 3) ? sx + 1 : (sel == 4) ? sx : longint'($urandom_range(0, int'(sx)));
          dy = (sel == 5) ? sy + 1 :
               (sel >= 15) ? longint'($urandom_range(0, int'(sy))) : 0;
          l += dx;
          t += dy;
        end
        queue_rect(CB'(l), CB'(t), CB'(w), CB'(h), ty, lst);
      end
    end
  endtask

  // Block idle: all sent, all results in, pipeline drained
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_runs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MERGE_MODE) mode_q = data[MODE_BITS-1:0];
    else tile_q = longint'(data);
  endtask

  task automatic set_config(input logic [MODE_BITS-1:0] mode, input int tile);
    wait_idle();
    write_reg(REG_MERGE_MODE, CFG_DATA_BITS'(mode));
    write_reg(REG_TILE_SIZE, CFG_DATA_BITS'(tile));
    n_settings++;
  endtask

  // Sender: bursts of transfers with random gaps in between
  always @(posedge clk_i) begin
    if (rst_ni && (!rect_ch.valid || rect_ch.ready)) begin
      if (gap_left > 0 || pending_rects.size() == 0) begin
        if (gap_left > 0) gap_left--;
        rect_ch.valid <= 1'b0;
      end else begin
        drv_rect = pending_rects.pop_front();
        rect_ch.valid         <= 1'b1;
        rect_ch.in_left       <= drv_rect.left;
        rect_ch.in_top        <= drv_rect.top;
        rect_ch.in_width      <= drv_rect.width;
        rect_ch.in_height     <= drv_rect.height;
        rect_ch.in_block_type <= drv_rect.btype;
        rect_ch.in_last       <= drv_rect.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // Receiver: stall style re-drawn at random from four ready patterns
  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 96 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0:       merged_ch.ready <= 1'b1;
      1:       merged_ch.ready <= 1'($urandom_range(0, 1));
      2:       merged_ch.ready <= (stall_tick % 8 == 0);
      default: merged_ch.ready <= (stall_tick % 32 < 12);
    endcase
  end

  // Monitor: predict on input transfers, check output transfers in order
  always @(posedge clk_i) begin
    rect_t seen;
    run_t  want;
    if (rst_ni) begin
      if (rect_ch.valid && rect_ch.ready) begin
        seen.left   = rect_ch.in_left;
        seen.top    = rect_ch.in_top;
        seen.width  = rect_ch.in_width;
        seen.height = rect_ch.in_height;
        seen.btype  = rect_ch.in_block_type;
        seen.last   = rect_ch.in_last;
        fold_rectangle(seen);
        n_accepted++;
      end
      if (merged_ch.valid && merged_ch.ready) begin
        if (expected_runs.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", n_checked));
        end else begin
          want = expected_runs.pop_front();
          if (merged_ch.out_left !== want.left)
            flag_mismatch($sformatf("result %0d left %0d, want %0d", n_checked,
                                    $signed(merged_ch.out_left), $signed(want.left)));
          if (merged_ch.out_top !== want.top)
            flag_mismatch($sformatf("result %0d top %0d, want %0d", n_checked,
                                    $signed(merged_ch.out_top), $signed(want.top)));
          if (merged_ch.out_width !== want.width)
            flag_mismatch($sformatf("result %0d width %0d, want %0d", n_checked,
                                    merged_ch.out_width, want.width));
          if (merged_ch.out_height !== want.height)
            flag_mismatch($sformatf("result %0d height %0d, want %0d", n_checked,
                                    merged_ch.out_height, want.height));
          if (merged_ch.out_block_type !== want.btype)
            flag_mismatch($sformatf("result %0d type %0d, want %0d", n_checked,
                                    merged_ch.out_block_type, want.btype));
          if (merged_ch.out_final !== want.is_final)
            flag_mismatch($sformatf("result %0d final %0b, want %0b", n_checked,
                                    merged_ch.out_final, want.is_final));
        end
        n_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("  timeout with %0d results outstanding", expected_runs.size());
      $display("[sorted_rectangle_run_merger_top] ERROR");
      $finish;
    end
  end

  // Sequencer: reset, directed lists per break test, then random phases
  initial begin
    logic [MODE_BITS-1:0] phase_mode [8];
    int                   phase_tile [8];
    int                   target;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = REG_MERGE_MODE;
    cfg_data_i            = '0;
    rect_ch.valid         = 1'b0;
    rect_ch.in_left       = '0;
    rect_ch.in_top        = '0;
    rect_ch.in_width      = '0;
    rect_ch.in_height     = '0;
    rect_ch.in_block_type = '0;
    rect_ch.in_last       = 1'b0;
    merged_ch.ready       = 1'b0;
    mode_q                = MODE_DIST;
    tile_q                = longint'(TILE_SIZE_RST);
    run_open              = 1'b0;
    {run_left, run_top, run_width, run_height}     = '0;
    {last_left, last_top, last_width, last_height} = '0;
    run_type              = '0;
    last_type             = '0;
    burst_left            = 0;
    gap_left              = 0;
    stall_tick            = 0;
    stall_style           = 0;
    n_settings            = 1;
    phase_mode = '{MODE_DIST, MODE_ADJ_SIZE, MODE_TYPE_DIST, MODE_SPARE,
                   MODE_DIST, MODE_ADJ_SIZE, MODE_TYPE_DIST, MODE_DIST};
    phase_tile = '{2047, 16, 1, $urandom_range(2, 1023),
                   0, 1024, $urandom_range(2, 1023), 1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Distance test at reset settings: lone last rectangle, extreme corners
    // with size saturation, threshold edge, break with last, flush and reopen
    queue_rect(0, 0, 1, 1, 0, 1'b1);
    queue_rect(-32768, -32768, 65535, 65535, 255, 1'b0);
    queue_rect(-32752, -32768, 65535, 65535, 255, 1'b0);
    queue_rect(-32741, -32756, 8, 8, 8'h80, 1'b0);
    queue_rect(-32732, -32744, 8, 8, 8'h80, 1'b0);
    queue_rect(1000, 2000, 3, 4, 8'h0F, 1'b1);
    queue_rect(32767, 32767, 0, 0, 8'h5A, 1'b0);
    queue_rect(32751, 32767, 0, 0, 8'hA5, 1'b1);

    // Adjacency: edge touch, gap, corner touch, size change with last
    set_config(MODE_ADJ_SIZE, 16);
    queue_rect(0, 0, 10, 10, 1, 1'b0);
    queue_rect(10, 0, 10, 10, 1, 1'b0);
    queue_rect(21, 0, 10, 10, 2, 1'b0);
    queue_rect(31, 10, 10, 10, 2, 1'b0);
    queue_rect(31, 20, 10, 11, 3, 1'b1);

    // Type or distance with a zero threshold
    set_config(MODE_TYPE_DIST, 0);
    queue_rect(5, 5, 2, 2, 3, 1'b0);
    queue_rect(5, 5, 2, 2, 3, 1'b0);
    queue_rect(5, 5, 2, 2, 4, 1'b0);
    queue_rect(6, 5, 2, 2, 4, 1'b1);

    // Spare selector, threshold 1024, diagonal on the circle edge
    set_config(MODE_SPARE, 1024);
    queue_rect(100, 100, 4, 4, 7, 1'b0);
    queue_rect(1124, 100, 4, 4, 7, 1'b0);
    queue_rect(1124, 100, 4, 4, 8, 1'b0);
    queue_rect(1848, 824, 4, 4, 8, 1'b1);

    // Random phases; each config change waits for a fully drained block
    for (int p = 0; p < 8; p++) begin
      set_config(phase_mode[p], phase_tile[p]);
      target = n_queued + PHASE_RECTS;
      while (n_queued < target) queue_row();
    end

    wait_idle();
    $display("  sent %0d rectangles, checked %0d merged results", n_accepted, n_checked);
    $display("  across %0d settings of break test and tile size", n_settings);
    if (n_errors == 0) begin
      $display("[sorted_rectangle_run_merger_top] OK");
    end else begin
      $display("  %0d mismatches", n_errors);
      $display("[sorted_rectangle_run_merger_top] ERROR");
    end
    $finish;
  end

endmodule
